### rtl/fifo_queue_with_search_assert.svh
// Assertion macros for the FIFO queue with search.
`ifndef FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH
`define FIFO_QUEUE_WITH_SEARCH_ASSERT_SVH

// Checked at every rising clock edge outside reset.
`define FQS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define FQS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/fqs_pkg.sv
// Shared types, constants and helper functions of the FIFO queue with search.
package fqs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DUMP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SEARCH,
      ST_DUMP
   } ctrl_state_type;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [PTR_W-1:0]       ptr_type;
   typedef logic [CNT_W-1:0]       cnt_type;

   typedef struct packed {
      status_type              status;
      logic                    found;
      logic [FIELD_WIDTH-1:0]  data_value;
      logic                    last;
   } rsp_word_type;

   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } emit_type;

   typedef struct packed {
      logic      we;
      ptr_type   waddr;
      value_type wdata;
      logic      re;
      ptr_type   raddr;
   } ram_cmd_type;

   typedef struct packed {
      logic    busy;
      cnt_type count;
   } ctrl_status_type;

   // Ring pointer step forward, wrapping at the queue depth.
   function automatic ptr_type ptr_inc(input ptr_type p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // Ring pointer step backward, wrapping at the queue depth.
   function automatic ptr_type ptr_dec(input ptr_type p);
      return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - PTR_W'(1);
   endfunction

   // 32-bit field to stored value: sign-extend, then keep the low bits.
   function automatic value_type to_value(input logic signed [FIELD_WIDTH-1:0] x);
      logic signed [63:0] ext;
      ext = 64'(x);
      return ext[VALUE_WIDTH-1:0];
   endfunction

   // Stored value to 32-bit field: sign-extend, then keep the low 32 bits.
   function automatic logic [FIELD_WIDTH-1:0] to_field(input value_type v);
      logic signed [VALUE_WIDTH-1:0] sv;
      logic signed [63:0]            ext;
      sv  = v;
      ext = 64'(sv);
      return ext[FIELD_WIDTH-1:0];
   endfunction

endpackage

### rtl/fqs_req_if.sv
// Request channel: operation word into the queue.
interface fqs_req_if import fqs_pkg::*; ();
   logic                           valid;
   logic                           ready;
   op_type                         op;
   logic signed [FIELD_WIDTH-1:0]  push_value;
   logic signed [FIELD_WIDTH-1:0]  search_key;

   modport source (output valid, output op, output push_value, output search_key,
                   input ready);
   modport sink   (input valid, input op, input push_value, input search_key,
                   output ready);
endinterface

### rtl/fqs_rsp_if.sv
// Response channel: result words out of the queue.
interface fqs_rsp_if import fqs_pkg::*; ();
   logic                           valid;
   logic                           ready;
   status_type                     status;
   logic                           found;
   logic signed [FIELD_WIDTH-1:0]  data_value;
   logic                           last;

   modport source (output valid, output status, output found, output data_value,
                   output last, input ready);
   modport sink   (input valid, input status, input found, input data_value,
                   input last, output ready);
endinterface

### rtl/fqs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module fqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/fqs_ctrl.sv
// Queue sequencer: pointers, count, RAM access and result generation.
module fqs_ctrl import fqs_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   fqs_req_if.sink         req_if,
   input  logic            emit_ok,
   output emit_type        emit,
   output ram_cmd_type     ram_cmd,
   input  value_type       ram_rdata,
   output ctrl_status_type ctrl_status
);
   ctrl_state_type state_ff, state_in;
   ptr_type        oldest_ff, oldest_in;
   ptr_type        newest_ff, newest_in;
   cnt_type        count_ff, count_in;
   ptr_type        scan_ptr_ff, scan_ptr_in;
   ptr_type        idx_ff, idx_in;
   value_type      key_ff, key_in;

   logic accept;
   logic hit;
   logic last_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         newest_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ptr_ff <= scan_ptr_in;
      idx_ff      <= idx_in;
      key_ff      <= key_in;
   end

   // The RAM read data is the entry at scan_ptr_ff while scanning.
   assign hit        = (ram_rdata == key_ff);
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in    = state_ff;
      oldest_in   = oldest_ff;
      newest_in   = newest_ff;
      count_in    = count_ff;
      scan_ptr_in = scan_ptr_ff;
      idx_in      = idx_ff;
      key_in      = key_ff;

      req_if.ready = 1'b0;
      accept       = 1'b0;

      emit.valid           = 1'b0;
      emit.word.status     = STATUS_OK;
      emit.word.found      = 1'b0;
      emit.word.data_value = '0;
      emit.word.last       = 1'b0;

      ram_cmd.we    = 1'b0;
      ram_cmd.waddr = newest_ff;
      ram_cmd.wdata = to_value(req_if.push_value);
      ram_cmd.re    = 1'b0;
      ram_cmd.raddr = oldest_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = emit_ok;
            accept       = req_if.valid && emit_ok;
            if (accept) begin
               unique case (req_if.op)
                  OP_PUSH: begin
                     emit.valid     = 1'b1;
                     emit.word.last = 1'b1;
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        emit.word.status = STATUS_FULL;
                     end else begin
                        ram_cmd.we = 1'b1;
                        newest_in  = ptr_inc(newest_ff);
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  OP_POP, OP_SEARCH, OP_DUMP: begin
                     if (count_ff == '0) begin
                        emit.valid       = 1'b1;
                        emit.word.status = STATUS_EMPTY;
                        emit.word.last   = 1'b1;
                     end else begin
                        ram_cmd.re = 1'b1;
                        idx_in     = '0;
                        priority case (req_if.op)
                           OP_POP: begin
                              ram_cmd.raddr = oldest_ff;
                              oldest_in     = ptr_inc(oldest_ff);
                              count_in      = count_ff - CNT_W'(1);
                              state_in      = ST_POP;
                           end
                           OP_SEARCH: begin
                              ram_cmd.raddr = oldest_ff;
                              scan_ptr_in   = oldest_ff;
                              key_in        = to_value(req_if.search_key);
                              state_in      = ST_SEARCH;
                           end
                           default: begin
                              ram_cmd.raddr = ptr_dec(newest_ff);
                              scan_ptr_in   = ptr_dec(newest_ff);
                              state_in      = ST_DUMP;
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_POP: begin
            if (emit_ok) begin
               emit.valid           = 1'b1;
               emit.word.data_value = to_field(ram_rdata);
               emit.word.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         ST_SEARCH: begin
            if (hit || last_entry) begin
               // Read data holds while the result waits for a free slot.
               if (emit_ok) begin
                  emit.valid      = 1'b1;
                  emit.word.found = hit;
                  emit.word.last  = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               ram_cmd.re    = 1'b1;
               ram_cmd.raddr = ptr_inc(scan_ptr_ff);
               scan_ptr_in   = ptr_inc(scan_ptr_ff);
               idx_in        = idx_ff + PTR_W'(1);
            end
         end

         ST_DUMP: begin
            if (emit_ok) begin
               emit.valid           = 1'b1;
               emit.word.data_value = to_field(ram_rdata);
               emit.word.last       = last_entry;
               if (last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  ram_cmd.re    = 1'b1;
                  ram_cmd.raddr = ptr_dec(scan_ptr_ff);
                  scan_ptr_in   = ptr_dec(scan_ptr_ff);
                  idx_in        = idx_ff + PTR_W'(1);
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ctrl_status.busy  = (state_ff != ST_IDLE);
      ctrl_status.count = count_ff;
   end
endmodule

### rtl/fqs_rsp_reg.sv
// Output register: holds one result word until the receiver takes it.
module fqs_rsp_reg import fqs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  emit_type emit,
   output logic     emit_ok,
   fqs_rsp_if.source rsp_if
);
   logic         valid_ff, valid_in;
   rsp_word_type word_ff, word_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   // Slot is free when empty or being drained this cycle.
   assign emit_ok = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (emit.valid && emit_ok) begin
         valid_in = 1'b1;
         word_in  = emit.word;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.status     = word_ff.status;
   assign rsp_if.found      = word_ff.found;
   assign rsp_if.data_value = word_ff.data_value;
   assign rsp_if.last       = word_ff.last;
endmodule

### rtl/fifo_queue_with_search.sv
// Top level of the bounded FIFO queue with linear search and dump.
//
// req_if takes one operation word: push, pop, search or dump. rsp_if returns
// result words: one for push, pop and search, one per stored entry for a dump
// (newest first, last set on the final word), and a single empty-status word
// for pop, search or dump on an empty queue.
// A push, or any operation on an empty queue, is done in the cycle it is
// accepted; a pop makes one RAM read; a search steps through the entries and
// ends early on the first match; a dump gives one result word per cycle while
// the output register has room. A new request is taken only once the last is
// done. The scans step one entry a cycle through the single read port of the
// entry RAM. A result word appears at rsp_if in the cycle after it is formed,
// held in a one-word output register.
// Reset clears pointers, count and control state at once; there is no clear
// pass over the RAM, whose contents are never read before being written.
// When the receiver stalls, the output register holds its word, the sequencer
// waits with a word to emit and req_if.ready stays low until the slot frees.
module fifo_queue_with_search import fqs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   fqs_req_if.sink   req_if,
   fqs_rsp_if.source rsp_if
);
`include "fifo_queue_with_search_assert.svh"

   emit_type        emit;
   logic            emit_ok;
   ram_cmd_type     ram_cmd;
   value_type       ram_rdata;
   ctrl_status_type ctrl_status;

   // Sequencer owns pointers and count; the ring store sits in the RAM.
   fqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .emit_ok     (emit_ok),
      .emit        (emit),
      .ram_cmd     (ram_cmd),
      .ram_rdata   (ram_rdata),
      .ctrl_status (ctrl_status)
   );

   // Push writes never coincide with a read of the same entry: every read is
   // issued after the write it depends on has completed.
   fqs_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_cmd.we),
      .waddr (ram_cmd.waddr),
      .wdata (ram_cmd.wdata),
      .re    (ram_cmd.re),
      .raddr (ram_cmd.raddr),
      .rdata (ram_rdata)
   );

   // Output register decouples the sequencer from the receiver.
   fqs_rsp_reg u_rsp_reg (
      .clock   (clock),
      .reset   (reset),
      .emit    (emit),
      .emit_ok (emit_ok),
      .rsp_if  (rsp_if)
   );

   `FQS_ASSERT(a_count_bound, (ctrl_status.count <= CNT_W'(QUEUE_DEPTH)), "entry count exceeds queue depth")
   `FQS_ASSERT(a_ready_idle, (req_if.ready |-> !ctrl_status.busy), "request taken while sequencer busy")
   `FQS_ASSERT(a_nonlast_is_dump, (rsp_if.valid && !rsp_if.last |-> rsp_if.status == STATUS_OK && !rsp_if.found), "non-final word is not a dump entry")
   `FQS_ASSERT(a_push_count, (req_if.valid && req_if.ready && req_if.op == OP_PUSH && ctrl_status.count != CNT_W'(QUEUE_DEPTH) |=> ctrl_status.count == $past(ctrl_status.count) + CNT_W'(1)), "push did not grow the count")
endmodule
